// ===== hw/rtl/tpda_pkg.sv =====
// ---------------------------------------------------------------------------
// tpda_pkg
// Shared widths, command codes and controller states for the tree path
// distance accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

package tpda_pkg;

    localparam int NODE_W  = 15;
    localparam int DEPTH_W = 15;
    localparam int DIST_W  = 16;
    localparam int TOTAL_W = 32;
    localparam int CMD_W   = 2;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // command codes; the fourth code is a no-op
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_VISIT = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SLOT,
        ST_LD_DEPTH,
        ST_LD_ROW,
        ST_VIS_DEPTH,
        ST_LIFT,
        ST_CLIMB,
        ST_MEET,
        ST_MEET_ANC,
        ST_MEET_DEPTH,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tpda_in_if.sv =====
// ---------------------------------------------------------------------------
// tpda_in_if
// Command channel: valid/ready handshake carrying one command word.
// ---------------------------------------------------------------------------
`default_nettype none

interface tpda_in_if
    import tpda_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] parent;

    modport source (output valid, output command, output node, output parent, input ready);
    modport sink   (input valid, input command, input node, input parent, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tpda_out_if.sv =====
// ---------------------------------------------------------------------------
// tpda_out_if
// Result channel: valid/ready handshake carrying one result word.
// ---------------------------------------------------------------------------
`default_nettype none

interface tpda_out_if
    import tpda_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [DIST_W-1:0]  distance;
    logic [NODE_W-1:0]  ancestor;
    logic [TOTAL_W-1:0] total;

    modport source (output valid, output distance, output ancestor, output total, input ready);
    modport sink   (input valid, input distance, input ancestor, input total, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tree_path_distance_accumulator_top.sv =====
// ---------------------------------------------------------------------------
// tree_path_distance_accumulator_top
// Rooted-tree path-length engine with binary-lifting ancestor tables.
// ---------------------------------------------------------------------------
// Loads a rooted tree one node at a time (parents before children), then
// walks it: each visit word finds the lowest common ancestor of the visited
// node and the current node, reports the edge count between them and adds
// it to a saturating running total. The ancestor table (LEVELS rows of NODES
// entries) and the depth store sit in synchronous memories with registered
// reads; entries of nodes never loaded read as garbage and must not be
// touched. Items are handled one at a time. A visit is a chain of dependent
// ancestor-table reads, one level per cycle, first lifting the deeper node
// and then climbing both nodes in step; a load fills the new row one level
// per cycle, and a no-op or a load of node zero goes straight to the result.
// A finished result waits in the output register, so the next word is
// accepted while it is pending. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module tree_path_distance_accumulator_top
    import tpda_pkg::*;
#(
    parameter int NODES  = 32768,
    parameter int LEVELS = 15
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tpda_in_if.sink    items,
    tpda_out_if.source results
);

    localparam int IDX_W = $clog2(NODES);
    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LEVELS - 1);
    localparam logic [LVL_W-1:0] LVL_ZERO = '0;

    // a node number together with its table slot
    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [IDX_W-1:0]  slot;
    } ent_t;

    // ---------------- memories ----------------
    ent_t               anc_mem [LEVELS][NODES];
    logic [DEPTH_W-1:0] dep_mem [NODES];

    // ancestor table ports: two reads at one level, one write
    logic [LVL_W-1:0] anc_rlvl;
    logic [IDX_W-1:0] anc_ra;
    logic [IDX_W-1:0] anc_rb;
    logic             anc_we;
    logic [LVL_W-1:0] anc_wlvl;
    ent_t             anc_wdata;
    ent_t             anc_q_a;
    ent_t             anc_q_b;

    // depth store ports: two reads, one write
    logic [IDX_W-1:0]   dep_ra;
    logic [IDX_W-1:0]   dep_rb;
    logic               dep_we;
    logic [DEPTH_W-1:0] dep_wdata;
    logic [DEPTH_W-1:0] dep_q_a;
    logic [DEPTH_W-1:0] dep_q_b;

    // read qualifiers: node zero reads as zero, same-entry write forwards
    logic rz_a;
    logic rz_b;
    logic zero_a_reg;
    logic zero_b_reg;
    logic fwd_a_reg;
    ent_t fwd_data_reg;

    // ---------------- control and datapath state ----------------
    state_t state_reg;
    state_t state_next;

    logic [LVL_W-1:0]   lvl_reg;
    logic               pend_reg;     // a table read is waiting to be taken
    logic               pair_reg;     // that read is a paired climb read
    logic [CMD_W-1:0]   cmd_reg;
    logic [NODE_W-1:0]  node_reg;
    logic [NODE_W-1:0]  parent_reg;
    logic [IDX_W-1:0]   nslot_reg;
    logic [IDX_W-1:0]   pslot_reg;
    logic [NODE_W-1:0]  cur_reg;
    logic [IDX_W-1:0]   cur_slot_reg;
    logic [TOTAL_W-1:0] total_reg;

    ent_t               s_reg;
    ent_t               e_reg;
    ent_t               meet_reg;
    logic [LEVELS-1:0]  dx_reg;
    logic [DEPTH_W-1:0] dn_reg;
    logic [DEPTH_W-1:0] dc_reg;
    logic [DIST_W-1:0]  res_dist_reg;
    logic [NODE_W-1:0]  res_anc_reg;

    logic               out_valid_reg;
    logic [DIST_W-1:0]  out_dist_reg;
    logic [NODE_W-1:0]  out_anc_reg;
    logic [TOTAL_W-1:0] out_total_reg;

    // slot reduction units
    logic             slot_done_n;
    logic             slot_done_p;
    logic             slot_done;
    logic [IDX_W-1:0] slot_n;
    logic [IDX_W-1:0] slot_p;

    // combinational helpers
    logic               accept;
    logic               out_load;
    ent_t               rd_a;
    ent_t               rd_b;
    ent_t               s_cur;
    ent_t               e_cur;
    logic [DEPTH_W-1:0] dn_val;
    logic [DEPTH_W-1:0] dc_val;
    logic [DEPTH_W-1:0] dm_val;
    logic [DEPTH_W-1:0] ld_depth;
    logic [DEPTH_W:0]   dx_wide;
    logic [DIST_W-1:0]  path_sum;
    logic [DIST_W-1:0]  twice_dm;
    logic [DIST_W-1:0]  dist_val;
    logic [TOTAL_W:0]   total_sum;
    logic [TOTAL_W-1:0] total_val;

    assign accept    = items.valid && items.ready;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || results.ready);
    assign slot_done = slot_done_n && slot_done_p;

    tpda_slot #(
        .NODES (NODES)
    ) u_slot_node (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .value (items.node),
        .done  (slot_done_n),
        .slot  (slot_n)
    );

    tpda_slot #(
        .NODES (NODES)
    ) u_slot_parent (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .value (items.parent),
        .done  (slot_done_p),
        .slot  (slot_p)
    );

    // ---------------- memories ----------------
    always_ff @(posedge clk)
    begin
        if (anc_we)
        begin
            anc_mem[anc_wlvl][nslot_reg] <= anc_wdata;
        end
        anc_q_a <= anc_mem[anc_rlvl][anc_ra];
        anc_q_b <= anc_mem[anc_rlvl][anc_rb];
    end

    always_ff @(posedge clk)
    begin
        if (dep_we)
        begin
            dep_mem[nslot_reg] <= dep_wdata;
        end
        dep_q_a <= dep_mem[dep_ra];
        dep_q_b <= dep_mem[dep_rb];
    end

    // qualified table read data
    assign rd_a = zero_a_reg ? '0 : (fwd_a_reg ? fwd_data_reg : anc_q_a);
    assign rd_b = zero_b_reg ? '0 : anc_q_b;

    // resolve the walkers: take a pending lift read, or a climb pair that differs
    always_comb
    begin
        s_cur = s_reg;
        e_cur = e_reg;
        if (pend_reg && !pair_reg)
        begin
            s_cur = rd_a;
        end
        else if (pend_reg && (rd_a.node != rd_b.node))
        begin
            s_cur = rd_a;
            e_cur = rd_b;
        end
    end

    // depth arithmetic
    always_comb
    begin
        dn_val    = (node_reg == '0) ? '0 : dep_q_a;
        dc_val    = (cur_reg == '0) ? '0 : dep_q_b;
        dm_val    = (meet_reg.node == '0) ? '0 : dep_q_a;
        ld_depth  = '0;
        if (parent_reg != '0)
        begin
            ld_depth = (dep_q_a == DEPTH_MAX) ? DEPTH_MAX : dep_q_a + DEPTH_W'(1);
        end
        dx_wide   = (dn_val < dc_val) ? {1'b0, dc_val - dn_val} : {1'b0, dn_val - dc_val};
        path_sum  = DIST_W'(dn_reg) + DIST_W'(dc_reg);
        twice_dm  = {dm_val, 1'b0};
        dist_val  = (path_sum >= twice_dm) ? path_sum - twice_dm : '0;
        total_sum = {1'b0, total_reg} + (TOTAL_W + 1)'(dist_val);
        total_val = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (items.valid)
                begin
                    case (items.command)
                        CMD_LOAD:  state_next = (items.node == '0) ? ST_DONE : ST_SLOT;
                        CMD_START: state_next = ST_SLOT;
                        CMD_VISIT: state_next = ST_SLOT;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_SLOT:
            begin
                if (slot_done)
                begin
                    case (cmd_reg)
                        CMD_LOAD:  state_next = ST_LD_DEPTH;
                        CMD_VISIT: state_next = ST_VIS_DEPTH;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_LD_DEPTH:   state_next = ST_LD_ROW;
            ST_LD_ROW:     state_next = (lvl_reg == LVL_LAST) ? ST_DONE : ST_LD_ROW;
            ST_VIS_DEPTH:  state_next = ST_LIFT;
            ST_LIFT:       state_next = (lvl_reg == LVL_LAST) ? ST_CLIMB : ST_LIFT;
            ST_CLIMB:      state_next = (lvl_reg == LVL_ZERO) ? ST_MEET : ST_CLIMB;
            ST_MEET:       state_next = (s_cur.node == e_cur.node) ? ST_MEET_DEPTH : ST_MEET_ANC;
            ST_MEET_ANC:   state_next = ST_MEET_DEPTH;
            ST_MEET_DEPTH: state_next = ST_DONE;
            ST_DONE:       state_next = out_load ? ST_IDLE : ST_DONE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // ---------------- memory control and handshake ----------------
    always_comb
    begin
        items.ready = (state_reg == ST_IDLE);
        anc_rlvl    = lvl_reg;
        anc_ra      = s_cur.slot;
        anc_rb      = e_cur.slot;
        rz_a        = (s_cur.node == '0);
        rz_b        = (e_cur.node == '0);
        anc_we      = 1'b0;
        anc_wlvl    = lvl_reg;
        anc_wdata   = s_cur;
        dep_ra      = slot_n;
        dep_rb      = cur_slot_reg;
        dep_we      = 1'b0;
        dep_wdata   = ld_depth;
        case (state_reg)
            ST_SLOT:
            begin
                // parent depth for a load, both end depths for a visit
                dep_ra = (cmd_reg == CMD_LOAD) ? slot_p : slot_n;
            end
            ST_LD_DEPTH:
            begin
                dep_we = 1'b1;
            end
            ST_LD_ROW:
            begin
                // write this level, fetch the next one through it
                anc_we = 1'b1;
            end
            ST_MEET:
            begin
                anc_rlvl = LVL_ZERO;
                dep_ra   = s_cur.slot;
            end
            ST_MEET_ANC:
            begin
                dep_ra = rd_a.slot;
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lvl_reg       <= '0;
            pend_reg      <= 1'b0;
            pair_reg      <= 1'b0;
            cur_reg       <= '0;
            cur_slot_reg  <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_SLOT:
                begin
                    if (slot_done && (cmd_reg == CMD_START))
                    begin
                        cur_reg      <= node_reg;
                        cur_slot_reg <= slot_n;
                        total_reg    <= '0;
                    end
                end
                ST_LD_DEPTH:
                begin
                    lvl_reg  <= '0;
                    pend_reg <= 1'b0;
                    pair_reg <= 1'b0;
                end
                ST_LD_ROW:
                begin
                    pend_reg <= 1'b1;
                    pair_reg <= 1'b0;
                    if (lvl_reg != LVL_LAST)
                    begin
                        lvl_reg <= lvl_reg + LVL_W'(1);
                    end
                end
                ST_VIS_DEPTH:
                begin
                    lvl_reg  <= '0;
                    pend_reg <= 1'b0;
                    pair_reg <= 1'b0;
                end
                ST_LIFT:
                begin
                    // only levels whose depth-difference bit is set move the walker
                    pend_reg <= dx_reg[lvl_reg];
                    pair_reg <= 1'b0;
                    if (lvl_reg != LVL_LAST)
                    begin
                        lvl_reg <= lvl_reg + LVL_W'(1);
                    end
                end
                ST_CLIMB:
                begin
                    pend_reg <= 1'b1;
                    pair_reg <= 1'b1;
                    if (lvl_reg != LVL_ZERO)
                    begin
                        lvl_reg <= lvl_reg - LVL_W'(1);
                    end
                end
                ST_MEET_DEPTH:
                begin
                    cur_reg      <= node_reg;
                    cur_slot_reg <= nslot_reg;
                    total_reg    <= total_val;
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        zero_a_reg   <= rz_a;
        zero_b_reg   <= rz_b;
        fwd_a_reg    <= anc_we && (anc_wlvl == anc_rlvl) && (nslot_reg == anc_ra);
        fwd_data_reg <= anc_wdata;

        if (accept)
        begin
            cmd_reg      <= items.command;
            node_reg     <= items.node;
            parent_reg   <= items.parent;
            res_dist_reg <= '0;
            res_anc_reg  <= '0;
        end

        if (out_load)
        begin
            out_dist_reg  <= res_dist_reg;
            out_anc_reg   <= res_anc_reg;
            out_total_reg <= total_reg;
        end

        case (state_reg)
            ST_SLOT:
            begin
                nslot_reg <= slot_n;
                pslot_reg <= slot_p;
            end
            ST_LD_DEPTH:
            begin
                // level 0 of the new row is the parent itself
                s_reg <= '{node: parent_reg, slot: pslot_reg};
            end
            ST_LD_ROW:
            begin
                s_reg <= s_cur;
            end
            ST_VIS_DEPTH:
            begin
                dn_reg <= dn_val;
                dc_reg <= dc_val;
                dx_reg <= LEVELS'(dx_wide);
                // the deeper end is lifted
                if (dn_val < dc_val)
                begin
                    s_reg <= '{node: cur_reg, slot: cur_slot_reg};
                    e_reg <= '{node: node_reg, slot: nslot_reg};
                end
                else
                begin
                    s_reg <= '{node: node_reg, slot: nslot_reg};
                    e_reg <= '{node: cur_reg, slot: cur_slot_reg};
                end
            end
            ST_LIFT, ST_CLIMB:
            begin
                s_reg <= s_cur;
                e_reg <= e_cur;
            end
            ST_MEET:
            begin
                meet_reg <= s_cur;
            end
            ST_MEET_ANC:
            begin
                meet_reg <= rd_a;
            end
            ST_MEET_DEPTH:
            begin
                res_dist_reg <= dist_val;
                res_anc_reg  <= meet_reg.node;
            end
            default:
            begin
            end
        endcase
    end

    assign results.valid    = out_valid_reg;
    assign results.distance = out_dist_reg;
    assign results.ancestor = out_anc_reg;
    assign results.total    = out_total_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tpda_slot.sv =====
// ---------------------------------------------------------------------------
// tpda_slot
// Two-stage node-number to table-slot reduction (node modulo NODES) by
// reciprocal multiplication and back-multiplication.
// ---------------------------------------------------------------------------
`default_nettype none

module tpda_slot
    import tpda_pkg::*;
#(
    parameter int NODES = 32768
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [NODE_W-1:0]        value,
    output logic                          done,
    output logic [$clog2(NODES)-1:0]      slot
);

    localparam int IDX_W = $clog2(NODES);
    localparam int SH    = NODE_W + IDX_W;
    localparam longint unsigned MULT = ((64'd1 << SH) + NODES - 1) / NODES;
    localparam logic [31:0] MULT_C  = 32'(MULT);
    localparam logic [31:0] NODES_C = 32'(NODES);

    logic              v1_reg;
    logic              done_reg;
    logic [NODE_W-1:0] x1_reg;
    logic [NODE_W-1:0] q1_reg;
    logic [IDX_W-1:0]  slot_reg;

    logic [31:0] product;
    logic [31:0] back;
    logic [31:0] rem;

    // quotient estimate is exact for 15-bit numerators
    assign product = 32'(value) * MULT_C;
    assign back    = 32'(q1_reg) * NODES_C;
    assign rem     = 32'(x1_reg) - back;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x1_reg <= value;
            q1_reg <= NODE_W'(product >> SH);
        end
        if (v1_reg)
        begin
            slot_reg <= rem[IDX_W-1:0];
        end
    end

    assign done = done_reg;
    assign slot = slot_reg;

endmodule

`default_nettype wire
